[sv/hid_pkg.sv]
// hid_pkg: shared constants, control struct and curve tables for the
// hilbert index distance block; depends on nothing
package hid_pkg;

  localparam int ORDER_W       = 5;
  localparam int IDX_W         = 33;
  localparam int DIST_W        = 20;
  localparam int MAX_ORDER_DEF = 16;
  // squared distance times 100 stays below 2^42 while the sum is in range
  localparam int V_W           = 42;
  localparam int ROOT_W        = V_W / 2;
  localparam int SQ_REM_W      = ROOT_W + 2;
  // bits of the squared distance that reach the scaled value
  localparam int SUM_IN_W      = 34;

  localparam logic [63:0]       SUM_LIMIT = 64'd11000000000;
  localparam logic [DIST_W-1:0] DIST_MAX  = '1;

  typedef logic [1:0] orient_t;
  typedef logic [1:0] quad_t;

  typedef struct packed {
    logic valid;
    logic invalid;
    logic sat;
  } ctl_t;

  // quadrant x offset in half sides, by orientation
  function automatic logic off_x(orient_t o, quad_t q);
    logic [3:0] row;
    case (o)
      2'd0:    row = 4'b0110;
      2'd1:    row = 4'b1100;
      2'd2:    row = 4'b1001;
      default: row = 4'b0011;
    endcase
    return row[q];
  endfunction

  // quadrant y offset in half sides, by orientation
  function automatic logic off_y(orient_t o, quad_t q);
    logic [3:0] row;
    case (o)
      2'd0:    row = 4'b1100;
      2'd1:    row = 4'b0110;
      2'd2:    row = 4'b0011;
      default: row = 4'b1001;
    endcase
    return row[q];
  endfunction

  // orientation for the levels below; first and last quadrants turn it
  function automatic orient_t next_orient(orient_t o, quad_t q);
    orient_t r;
    r = o;
    if (q == 2'd0) begin
      case (o)
        2'd0:    r = 2'd1;
        2'd1:    r = 2'd0;
        2'd2:    r = 2'd3;
        default: r = 2'd2;
      endcase
    end else if (q == 2'd3) begin
      case (o)
        2'd0:    r = 2'd3;
        2'd1:    r = 2'd2;
        2'd2:    r = 2'd1;
        default: r = 2'd0;
      endcase
    end
    return r;
  endfunction

endpackage

[sv/hid_level_cell.sv]
// hid_level_cell: one curve level for both points, registered
// depends on hid_pkg
module hid_level_cell #(
  parameter int MAX_ORDER = hid_pkg::MAX_ORDER_DEF,
  parameter int LEVEL     = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  hid_pkg::ctl_t              ctl_in,
  input  logic [hid_pkg::ORDER_W-1:0] order_in,
  input  logic [2*MAX_ORDER-1:0]     rem_a_in,
  input  logic [2*MAX_ORDER-1:0]     rem_b_in,
  input  hid_pkg::orient_t           orient_a_in,
  input  hid_pkg::orient_t           orient_b_in,
  input  logic [MAX_ORDER-1:0]       xa_in,
  input  logic [MAX_ORDER-1:0]       ya_in,
  input  logic [MAX_ORDER-1:0]       xb_in,
  input  logic [MAX_ORDER-1:0]       yb_in,
  output hid_pkg::ctl_t              ctl_out,
  output logic [hid_pkg::ORDER_W-1:0] order_out,
  output logic [2*MAX_ORDER-1:0]     rem_a_out,
  output logic [2*MAX_ORDER-1:0]     rem_b_out,
  output hid_pkg::orient_t           orient_a_out,
  output hid_pkg::orient_t           orient_b_out,
  output logic [MAX_ORDER-1:0]       xa_out,
  output logic [MAX_ORDER-1:0]       ya_out,
  output logic [MAX_ORDER-1:0]       xb_out,
  output logic [MAX_ORDER-1:0]       yb_out
);

  localparam int ORDER_W = hid_pkg::ORDER_W;
  localparam logic [ORDER_W-1:0] LEVEL_CODE = ORDER_W'(LEVEL);

  logic             active;
  hid_pkg::quad_t   qa, qb;
  hid_pkg::orient_t orient_a_next, orient_b_next;
  logic [MAX_ORDER-1:0] xa_next, ya_next, xb_next, yb_next;

  assign qa     = rem_a_in[2*LEVEL-1 -: 2];
  assign qb     = rem_b_in[2*LEVEL-1 -: 2];
  // levels above the item's order leave everything as it is
  assign active = (order_in >= LEVEL_CODE);

  always_comb begin
    xa_next       = xa_in;
    ya_next       = ya_in;
    xb_next       = xb_in;
    yb_next       = yb_in;
    orient_a_next = orient_a_in;
    orient_b_next = orient_b_in;
    if (active) begin
      xa_next[LEVEL-1] = hid_pkg::off_x(orient_a_in, qa);
      ya_next[LEVEL-1] = hid_pkg::off_y(orient_a_in, qa);
      xb_next[LEVEL-1] = hid_pkg::off_x(orient_b_in, qb);
      yb_next[LEVEL-1] = hid_pkg::off_y(orient_b_in, qb);
      orient_a_next    = hid_pkg::next_orient(orient_a_in, qa);
      orient_b_next    = hid_pkg::next_orient(orient_b_in, qb);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    order_out    <= order_in;
    rem_a_out    <= rem_a_in;
    rem_b_out    <= rem_b_in;
    orient_a_out <= orient_a_next;
    orient_b_out <= orient_b_next;
    xa_out       <= xa_next;
    ya_out       <= ya_next;
    xb_out       <= xb_next;
    yb_out       <= yb_next;
  end

endmodule

[sv/hid_sqrt_cell.sv]
// hid_sqrt_cell: one root bit of the digit-by-digit square root, registered
// depends on hid_pkg
module hid_sqrt_cell (
  input  logic                         clk,
  input  logic                         rst,
  input  hid_pkg::ctl_t                ctl_in,
  input  logic [hid_pkg::V_W-1:0]      v_in,
  input  logic [hid_pkg::ROOT_W-1:0]   root_in,
  input  logic [hid_pkg::SQ_REM_W-1:0] rem_in,
  output hid_pkg::ctl_t                ctl_out,
  output logic [hid_pkg::V_W-1:0]      v_out,
  output logic [hid_pkg::ROOT_W-1:0]   root_out,
  output logic [hid_pkg::SQ_REM_W-1:0] rem_out
);

  localparam int V_W      = hid_pkg::V_W;
  localparam int ROOT_W   = hid_pkg::ROOT_W;
  localparam int SQ_REM_W = hid_pkg::SQ_REM_W;
  localparam int CUR_W    = SQ_REM_W + 2;

  logic [CUR_W-1:0] cur, trial, diff;
  logic             ge;

  // bring down the next two bits and try root*4+1
  assign cur   = {rem_in, v_in[V_W-1 -: 2]};
  assign trial = CUR_W'({root_in, 2'b01});
  assign ge    = (cur >= trial);
  assign diff  = cur - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    v_out    <= {v_in[V_W-3:0], 2'b00};
    root_out <= {root_in[ROOT_W-2:0], ge};
    rem_out  <= ge ? diff[SQ_REM_W-1:0] : cur[SQ_REM_W-1:0];
  end

endmodule

[sv/hilbert_index_distance_top.sv]
// hilbert_index_distance_top: hilbert index pair to rounded tenths distance
// depends on hid_pkg, hid_level_cell, hid_sqrt_cell
//
// usage
//   input channel: an item (curve_order, first_index, second_index) is taken
//   at a rising edge with start high and busy low. busy is low at all times
//   outside reset, so one item can be taken in every cycle.
//   result channel: done is high for exactly one cycle with distance_tenths
//   and invalid; the receiver has no way to hold a result off.
// pipeline and throughput
//   one item per cycle is sustained outside reset. the pipeline is the
//   intake register, the row of MAX_ORDER level cells (one curve level
//   each), three squared distance stages, the scale register, the row of 21
//   square root cells (one root bit each) and the output register: six
//   registered stages around the two rows.
// reset
//   rst (synchronous, active high) clears every valid flag in both rows, so
//   items in flight are dropped and no done pulse follows; busy is high while
//   rst is held.
// results
//   an index of zero, an index above 4^order or an order above MAX_ORDER give
//   invalid high and a zero distance; a distance beyond the 20-bit field
//   saturates at all ones.
module hilbert_index_distance_top #(
  parameter int MAX_ORDER = hid_pkg::MAX_ORDER_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [hid_pkg::ORDER_W-1:0] curve_order,
  input  logic [hid_pkg::IDX_W-1:0]   first_index,
  input  logic [hid_pkg::IDX_W-1:0]   second_index,
  output logic                        done,
  output logic [hid_pkg::DIST_W-1:0]  distance_tenths,
  output logic                        invalid
);

  localparam int ORDER_W  = hid_pkg::ORDER_W;
  localparam int REM_W    = 2 * MAX_ORDER;
  localparam int SQ_W     = 2 * MAX_ORDER;
  localparam int SUM_W    = 2 * MAX_ORDER + 1;
  localparam int V_W      = hid_pkg::V_W;
  localparam int ROOT_W   = hid_pkg::ROOT_W;
  localparam int SQ_REM_W = hid_pkg::SQ_REM_W;
  localparam int DIST_W   = hid_pkg::DIST_W;
  localparam int RND_W    = ROOT_W + 1;
  localparam logic [ORDER_W-1:0] MAX_ORDER_CODE = ORDER_W'(MAX_ORDER);

  // ---------------------------------------------------------------- intake
  logic        accept;
  logic [63:0] total, a_ext, b_ext, rem_a64, rem_b64;
  logic        item_bad;

  assign busy   = rst;
  assign accept = start && !busy;

  assign total   = 64'd1 << {curve_order, 1'b0};
  assign a_ext   = 64'(first_index);
  assign b_ext   = 64'(second_index);
  assign rem_a64 = a_ext - 64'd1;
  assign rem_b64 = b_ext - 64'd1;
  assign item_bad = (curve_order > MAX_ORDER_CODE) || (a_ext == 64'd0) ||
                    (b_ext == 64'd0) || (a_ext > total) || (b_ext > total);

  // chain taps: index k feeds the cell for level MAX_ORDER - k
  hid_pkg::ctl_t      lvl_ctl    [MAX_ORDER+1];
  logic [ORDER_W-1:0] lvl_order  [MAX_ORDER+1];
  logic [REM_W-1:0]   lvl_rem_a  [MAX_ORDER+1];
  logic [REM_W-1:0]   lvl_rem_b  [MAX_ORDER+1];
  hid_pkg::orient_t   lvl_or_a   [MAX_ORDER+1];
  hid_pkg::orient_t   lvl_or_b   [MAX_ORDER+1];
  logic [MAX_ORDER-1:0] lvl_xa   [MAX_ORDER+1];
  logic [MAX_ORDER-1:0] lvl_ya   [MAX_ORDER+1];
  logic [MAX_ORDER-1:0] lvl_xb   [MAX_ORDER+1];
  logic [MAX_ORDER-1:0] lvl_yb   [MAX_ORDER+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      lvl_ctl[0] <= '0;
    end else begin
      lvl_ctl[0].valid   <= accept;
      lvl_ctl[0].invalid <= item_bad;
      lvl_ctl[0].sat     <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    lvl_order[0] <= curve_order;
    lvl_rem_a[0] <= rem_a64[REM_W-1:0];
    lvl_rem_b[0] <= rem_b64[REM_W-1:0];
  end

  // every point starts at the origin with orientation zero
  assign lvl_or_a[0] = '0;
  assign lvl_or_b[0] = '0;
  assign lvl_xa[0]   = '0;
  assign lvl_ya[0]   = '0;
  assign lvl_xb[0]   = '0;
  assign lvl_yb[0]   = '0;

  // ------------------------------------------------------ level cell row
  for (genvar k = 0; k < MAX_ORDER; k++) begin : g_level
    hid_level_cell #(
      .MAX_ORDER (MAX_ORDER),
      .LEVEL     (MAX_ORDER - k)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .ctl_in       (lvl_ctl[k]),
      .order_in     (lvl_order[k]),
      .rem_a_in     (lvl_rem_a[k]),
      .rem_b_in     (lvl_rem_b[k]),
      .orient_a_in  (lvl_or_a[k]),
      .orient_b_in  (lvl_or_b[k]),
      .xa_in        (lvl_xa[k]),
      .ya_in        (lvl_ya[k]),
      .xb_in        (lvl_xb[k]),
      .yb_in        (lvl_yb[k]),
      .ctl_out      (lvl_ctl[k+1]),
      .order_out    (lvl_order[k+1]),
      .rem_a_out    (lvl_rem_a[k+1]),
      .rem_b_out    (lvl_rem_b[k+1]),
      .orient_a_out (lvl_or_a[k+1]),
      .orient_b_out (lvl_or_b[k+1]),
      .xa_out       (lvl_xa[k+1]),
      .ya_out       (lvl_ya[k+1]),
      .xb_out       (lvl_xb[k+1]),
      .yb_out       (lvl_yb[k+1])
    );
  end

  // ------------------------------------------------- squared distance
  // the 1-based offset cancels in the differences
  hid_pkg::ctl_t        d_ctl, m_ctl, s_ctl;
  logic [MAX_ORDER-1:0] dx, dy;
  logic [SQ_W-1:0]      sq_x, sq_y;
  logic [SUM_W-1:0]     sum;
  logic [MAX_ORDER-1:0] xa_f, ya_f, xb_f, yb_f;

  assign xa_f = lvl_xa[MAX_ORDER];
  assign ya_f = lvl_ya[MAX_ORDER];
  assign xb_f = lvl_xb[MAX_ORDER];
  assign yb_f = lvl_yb[MAX_ORDER];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_ctl <= '0;
      m_ctl <= '0;
      s_ctl <= '0;
    end else begin
      d_ctl <= lvl_ctl[MAX_ORDER];
      m_ctl <= d_ctl;
      s_ctl <= m_ctl;
    end
  end

  always_ff @(posedge clk) begin
    dx   <= (xa_f > xb_f) ? (xa_f - xb_f) : (xb_f - xa_f);
    dy   <= (ya_f > yb_f) ? (ya_f - yb_f) : (yb_f - ya_f);
    sq_x <= SQ_W'(dx) * SQ_W'(dx);
    sq_y <= SQ_W'(dy) * SQ_W'(dy);
    sum  <= SUM_W'(sq_x) + SUM_W'(sq_y);
  end

  // ------------------------------------------- scale by 100, saturation
  logic [63:0]    sum64;
  logic [V_W-1:0] sum_v, v_scaled;

  assign sum64    = 64'(sum);
  assign sum_v    = V_W'(sum64[hid_pkg::SUM_IN_W-1:0]);
  // 100 = 64 + 32 + 4
  assign v_scaled = (sum_v << 6) + (sum_v << 5) + (sum_v << 2);

  hid_pkg::ctl_t           sq_ctl  [ROOT_W+1];
  logic [V_W-1:0]          sq_v    [ROOT_W+1];
  logic [ROOT_W-1:0]       sq_root [ROOT_W+1];
  logic [SQ_REM_W-1:0]     sq_rem  [ROOT_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_ctl[0] <= '0;
    end else begin
      sq_ctl[0].valid   <= s_ctl.valid;
      sq_ctl[0].invalid <= s_ctl.invalid;
      sq_ctl[0].sat     <= (sum64 > hid_pkg::SUM_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    sq_v[0] <= v_scaled;
  end

  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;

  // ------------------------------------------------ square root cell row
  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    hid_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl_in   (sq_ctl[j]),
      .v_in     (sq_v[j]),
      .root_in  (sq_root[j]),
      .rem_in   (sq_rem[j]),
      .ctl_out  (sq_ctl[j+1]),
      .v_out    (sq_v[j+1]),
      .root_out (sq_root[j+1]),
      .rem_out  (sq_rem[j+1])
    );
  end

  // ------------------------------------------------ rounding and output
  // remainder is v - s*s, so rounding up is remainder above s
  hid_pkg::ctl_t      f_ctl;
  logic [ROOT_W-1:0]  root_f;
  logic [RND_W-1:0]   rounded;
  logic               round_up;
  logic               too_big;

  assign f_ctl    = sq_ctl[ROOT_W];
  assign root_f   = sq_root[ROOT_W];
  assign round_up = (sq_rem[ROOT_W] > SQ_REM_W'(root_f));
  assign rounded  = RND_W'(root_f) + RND_W'(round_up);
  assign too_big  = f_ctl.sat || (rounded > RND_W'(hid_pkg::DIST_MAX));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    invalid <= f_ctl.invalid;
    if (f_ctl.invalid) begin
      distance_tenths <= '0;
    end else if (too_big) begin
      distance_tenths <= hid_pkg::DIST_MAX;
    end else begin
      distance_tenths <= rounded[DIST_W-1:0];
    end
  end

endmodule
